### hdl/mrm_pkg.sv
// Shared types and constants for the register machine execute block.
`timescale 1ns / 1ps
package mrm_pkg;

  localparam int unsigned DefStackDepth = 16;
  localparam int unsigned DefNumRegs    = 4;
  localparam int unsigned QueueDepth    = 2;

  localparam int unsigned FuncW  = 4;
  localparam int unsigned RegIdW = 2;
  localparam int unsigned DataW  = 32;
  localparam int unsigned PcW    = 16;
  localparam int unsigned FlagW  = 2;
  localparam int unsigned FaultW = 2;

  // instruction encodings on the func field
  localparam logic [FuncW-1:0] FUNC_MOV  = 4'd0;
  localparam logic [FuncW-1:0] FUNC_CMP  = 4'd1;
  localparam logic [FuncW-1:0] FUNC_JE   = 4'd2;
  localparam logic [FuncW-1:0] FUNC_JG   = 4'd3;
  localparam logic [FuncW-1:0] FUNC_JL   = 4'd4;
  localparam logic [FuncW-1:0] FUNC_JMP  = 4'd5;
  localparam logic [FuncW-1:0] FUNC_PUSH = 4'd6;
  localparam logic [FuncW-1:0] FUNC_POP  = 4'd7;
  localparam logic [FuncW-1:0] FUNC_CALL = 4'd8;
  localparam logic [FuncW-1:0] FUNC_RET  = 4'd9;
  localparam logic [FuncW-1:0] FUNC_ADD  = 4'd10;
  localparam logic [FuncW-1:0] FUNC_SUB  = 4'd11;

  localparam logic [FaultW-1:0] FAULT_NONE = 2'd0;
  localparam logic [FaultW-1:0] FAULT_OVF  = 2'd1;
  localparam logic [FaultW-1:0] FAULT_UNF  = 2'd2;
  localparam logic [FaultW-1:0] FAULT_RSV  = 2'd3;

  localparam logic signed [FlagW-1:0] FLAG_LT = -2'sd1;
  localparam logic signed [FlagW-1:0] FLAG_EQ = 2'sd0;
  localparam logic signed [FlagW-1:0] FLAG_GT = 2'sd1;
  localparam logic signed [FlagW-1:0] FLAG_BAD = -2'sd2;

  typedef enum logic [3:0] {
    OP_MOV, OP_CMP, OP_JE, OP_JG, OP_JL, OP_JMP,
    OP_PUSH, OP_POP, OP_CALL, OP_RET, OP_ADD, OP_SUB, OP_NOP
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [RegIdW-1:0] dst;
    logic [RegIdW-1:0] src;
    logic              use_src;
    logic [DataW-1:0]  imm;
  } uop_t;

endpackage

### hdl/mrm_front.sv
// Front end: decodes incoming instructions and buffers them in a short queue.
`timescale 1ns / 1ps
module mrm_front
  import mrm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FuncW-1:0]  func_i,
  input  logic [RegIdW-1:0] dst_reg_i,
  input  logic [RegIdW-1:0] src_reg_i,
  input  logic              use_src_reg_i,
  input  logic [DataW-1:0]  immediate_i,
  output logic              uop_valid_o,
  input  logic              uop_ready_i,
  output uop_t              uop_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  uop_t            dec;
  uop_t            q_mem [QueueDepth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  always_comb begin
    dec.dst     = dst_reg_i;
    dec.src     = src_reg_i;
    dec.use_src = use_src_reg_i;
    dec.imm     = immediate_i;
    case (func_i)
      FUNC_MOV:  dec.op = OP_MOV;
      FUNC_CMP:  dec.op = OP_CMP;
      FUNC_JE:   dec.op = OP_JE;
      FUNC_JG:   dec.op = OP_JG;
      FUNC_JL:   dec.op = OP_JL;
      FUNC_JMP:  dec.op = OP_JMP;
      FUNC_PUSH: dec.op = OP_PUSH;
      FUNC_POP:  dec.op = OP_POP;
      FUNC_CALL: dec.op = OP_CALL;
      FUNC_RET:  dec.op = OP_RET;
      FUNC_ADD:  dec.op = OP_ADD;
      FUNC_SUB:  dec.op = OP_SUB;
      default:   dec.op = OP_NOP;
    endcase
  end

  assign in_ready_o  = (cnt_q != CntW'(QueueDepth));
  assign uop_valid_o = (cnt_q != '0);
  assign uop_o       = q_mem[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = uop_valid_o && uop_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wptr_q] <= dec;
    end
  end

endmodule

### hdl/mrm_back.sv
// Back end: register read stage, execute stage with machine state, result register.
`timescale 1ns / 1ps
module mrm_back
  import mrm_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DefStackDepth,
  parameter int unsigned NUM_REGS    = DefNumRegs
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     uop_valid_i,
  output logic                     uop_ready_o,
  input  uop_t                     uop_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [PcW-1:0]           next_pc_o,
  output logic signed [FlagW-1:0]  flag_out_o,
  output logic signed [DataW-1:0]  written_value_o,
  output logic [FaultW-1:0]        fault_o
);

  localparam int unsigned RiW = $clog2(NUM_REGS);
  localparam int unsigned ExW = RiW + RegIdW;
  localparam int unsigned SiW = $clog2(STACK_DEPTH);
  localparam int unsigned LvW = $clog2(STACK_DEPTH + 1);

  // register file, valid bits stand in for the reset value
  logic [DataW-1:0] rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld_q;
  logic [DataW-1:0] stk_mem [STACK_DEPTH];

  // read stage
  logic             rd_valid_q;
  uop_t             rd_uop_q;
  logic [DataW-1:0] rd_a_q, rd_b_q;
  logic             rd_dst_ok_q;
  logic             rd_load;
  logic [ExW-1:0]   hd_a_ext, hd_b_ext, wr_ext;
  logic             hd_a_ok, hd_b_ok;

  // machine state
  logic [PcW-1:0]          pc_q, pc_d;
  logic signed [FlagW-1:0] flag_q, flag_d;
  logic [LvW-1:0]          lvl_q, lvl_d;
  logic [DataW-1:0]        top_q;

  // execute
  logic             ex_fire;
  logic [DataW-1:0] op_b, wr_data, push_data;
  logic             wr_en, push_en, pop_en;
  logic [FaultW-1:0] fault;
  logic [PcW-1:0]   pc_inc;
  logic             stk_full, stk_empty;
  logic [LvW-1:0]   rd_lvl;
  logic [RiW-1:0]   wr_idx;

  assign ex_fire     = rd_valid_q && (!out_valid_o || out_ready_i);
  assign rd_load     = uop_valid_i && (!rd_valid_q || ex_fire);
  assign uop_ready_o = !rd_valid_q || ex_fire;

  assign hd_a_ext = {{RiW{1'b0}}, uop_i.dst};
  assign hd_b_ext = {{RiW{1'b0}}, uop_i.src};
  assign wr_ext   = {{RiW{1'b0}}, rd_uop_q.dst};
  assign hd_a_ok  = hd_a_ext < ExW'(NUM_REGS);
  assign hd_b_ok  = hd_b_ext < ExW'(NUM_REGS);
  assign wr_idx   = wr_ext[RiW-1:0];

  assign op_b      = rd_uop_q.use_src ? rd_b_q : rd_uop_q.imm;
  assign pc_inc    = pc_q + 1'b1;
  assign stk_full  = (lvl_q == LvW'(STACK_DEPTH));
  assign stk_empty = (lvl_q == '0);
  assign rd_lvl    = lvl_q - LvW'(2);

  always_comb begin
    pc_d      = pc_inc;
    flag_d    = flag_q;
    lvl_d     = lvl_q;
    wr_en     = 1'b0;
    wr_data   = rd_a_q;
    push_en   = 1'b0;
    pop_en    = 1'b0;
    push_data = rd_a_q;
    fault     = FAULT_NONE;
    case (rd_uop_q.op)
      OP_MOV: begin
        wr_en   = rd_dst_ok_q;
        wr_data = op_b;
      end
      OP_CMP: begin
        if ($signed(rd_a_q) == $signed(op_b)) begin
          flag_d = FLAG_EQ;
        end else if ($signed(rd_a_q) > $signed(op_b)) begin
          flag_d = FLAG_GT;
        end else begin
          flag_d = FLAG_LT;
        end
      end
      OP_JE: if (flag_q == FLAG_EQ) pc_d = rd_a_q[PcW-1:0];
      OP_JG: if (flag_q == FLAG_GT) pc_d = rd_a_q[PcW-1:0];
      OP_JL: if (flag_q == FLAG_LT) pc_d = rd_a_q[PcW-1:0];
      OP_JMP: pc_d = rd_a_q[PcW-1:0];
      OP_PUSH: begin
        if (stk_full) begin
          fault = FAULT_OVF;
        end else begin
          push_en = 1'b1;
        end
      end
      OP_POP: begin
        if (stk_empty) begin
          fault = FAULT_UNF;
        end else begin
          pop_en  = 1'b1;
          wr_en   = rd_dst_ok_q;
          wr_data = top_q;
        end
      end
      OP_CALL: begin
        push_data = {{(DataW-PcW){1'b0}}, pc_inc};
        if (stk_full) begin
          fault = FAULT_OVF;
        end else begin
          push_en = 1'b1;
        end
        pc_d = rd_a_q[PcW-1:0];
      end
      OP_RET: begin
        if (stk_empty) begin
          fault = FAULT_UNF;
        end else begin
          pop_en = 1'b1;
          pc_d   = top_q[PcW-1:0];
        end
      end
      OP_ADD: begin
        wr_en   = rd_dst_ok_q;
        wr_data = rd_a_q + op_b;
      end
      OP_SUB: begin
        wr_en   = rd_dst_ok_q;
        wr_data = rd_a_q - op_b;
      end
      default: ;
    endcase
    if (push_en) begin
      lvl_d = lvl_q + 1'b1;
    end else if (pop_en) begin
      lvl_d = lvl_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
      pc_q        <= '0;
      flag_q      <= FLAG_EQ;
      lvl_q       <= '0;
      rf_vld_q    <= '0;
    end else begin
      if (uop_ready_o) begin
        rd_valid_q <= uop_valid_i;
      end
      if (ex_fire) begin
        out_valid_o <= 1'b1;
        pc_q        <= pc_d;
        flag_q      <= flag_d;
        lvl_q       <= lvl_d;
        if (wr_en) begin
          rf_vld_q[wr_idx] <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // register file read with forwarding from the instruction executing now
  always_ff @(posedge clk_i) begin
    if (rd_load) begin
      rd_uop_q    <= uop_i;
      rd_dst_ok_q <= hd_a_ok;
      if (ex_fire && wr_en && (wr_ext == hd_a_ext)) begin
        rd_a_q <= wr_data;
      end else if (!hd_a_ok || !rf_vld_q[hd_a_ext[RiW-1:0]]) begin
        rd_a_q <= '0;
      end else begin
        rd_a_q <= rf_mem[hd_a_ext[RiW-1:0]];
      end
      if (ex_fire && wr_en && (wr_ext == hd_b_ext)) begin
        rd_b_q <= wr_data;
      end else if (!hd_b_ok || !rf_vld_q[hd_b_ext[RiW-1:0]]) begin
        rd_b_q <= '0;
      end else begin
        rd_b_q <= rf_mem[hd_b_ext[RiW-1:0]];
      end
    end
    if (ex_fire && wr_en) begin
      rf_mem[wr_idx] <= wr_data;
    end
  end

  // stack memory; top_q always mirrors the entry below the level
  always_ff @(posedge clk_i) begin
    if (ex_fire && push_en) begin
      stk_mem[lvl_q[SiW-1:0]] <= push_data;
      top_q <= push_data;
    end else if (ex_fire && pop_en) begin
      top_q <= stk_mem[rd_lvl[SiW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_fire) begin
      next_pc_o       <= pc_d;
      flag_out_o      <= flag_d;
      written_value_o <= wr_en ? wr_data : rd_a_q;
      fault_o         <= fault;
    end
  end

endmodule

### hdl/mini_register_machine_execute.sv
// Top level of the register machine execute block: front end, queue and back end.
//
// Usage: one instruction per beat on the input channel (valid/ready), one
// result beat per instruction on the output channel, in order.
// Input fields: func, dst_reg, src_reg, use_src_reg, immediate.
// Output fields: next_pc, flag_out, written_value, fault.
// Path: an accepted instruction passes through the queue, the register read
// stage and the execute stage into the result register.
// Throughput: one instruction per cycle while results are taken; the
// execute stage updates pc, flag, registers and stack together, and register
// reads are forwarded from the instruction ahead, so back-to-back dependent
// instructions never wait.
// Reset: registers, flag, pc and stack level clear at once; the block takes
// instructions in the first cycle after reset. Stack contents are not
// cleared; only entries below the level are ever used.
// Stall: when the result is not taken, the result register holds, the read
// stage holds, and the two-entry queue fills before in_ready_o drops.
`timescale 1ns / 1ps
module mini_register_machine_execute
  import mrm_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DefStackDepth,
  parameter int unsigned NUM_REGS    = DefNumRegs
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [FuncW-1:0]        func_i,
  input  logic [RegIdW-1:0]       dst_reg_i,
  input  logic [RegIdW-1:0]       src_reg_i,
  input  logic                    use_src_reg_i,
  input  logic [DataW-1:0]        immediate_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [PcW-1:0]          next_pc_o,
  output logic signed [FlagW-1:0] flag_out_o,
  output logic signed [DataW-1:0] written_value_o,
  output logic [FaultW-1:0]       fault_o
);

  logic uop_valid, uop_ready;
  uop_t uop;

  mrm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .dst_reg_i     (dst_reg_i),
    .src_reg_i     (src_reg_i),
    .use_src_reg_i (use_src_reg_i),
    .immediate_i   (immediate_i),
    .uop_valid_o   (uop_valid),
    .uop_ready_i   (uop_ready),
    .uop_o         (uop)
  );

  mrm_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .NUM_REGS    (NUM_REGS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .uop_valid_i     (uop_valid),
    .uop_ready_o     (uop_ready),
    .uop_i           (uop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .next_pc_o       (next_pc_o),
    .flag_out_o      (flag_out_o),
    .written_value_o (written_value_o),
    .fault_o         (fault_o)
  );

  a_fault_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fault_o != FAULT_RSV))
    else $error("reserved fault code on result");

  a_flag_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (flag_out_o != FLAG_BAD))
    else $error("invalid compare flag on result");

  a_queue_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uop_valid && !uop_ready) |=> (uop_valid && $stable(uop)))
    else $error("queue head changed while back end stalled");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(next_pc_o) && $stable(fault_o)))
    else $error("result changed while stalled");

endmodule
